@@ hw/rtl/bchd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bchd_pkg;

  // one-hot button states
  typedef enum logic [6:0] {
    ST_IDLE         = 7'b0000001,
    ST_PRESSED      = 7'b0000010,
    ST_DOWN         = 7'b0000100,
    ST_RELEASED     = 7'b0001000,
    ST_UP           = 7'b0010000,
    ST_WAIT_RELEASE = 7'b0100000,
    ST_DEBOUNCE     = 7'b1000000
  } btn_state_e;

  // reported state codes
  localparam logic [2:0] CODE_IDLE         = 3'd0;
  localparam logic [2:0] CODE_PRESSED      = 3'd1;
  localparam logic [2:0] CODE_DOWN         = 3'd2;
  localparam logic [2:0] CODE_RELEASED     = 3'd3;
  localparam logic [2:0] CODE_UP           = 3'd4;
  localparam logic [2:0] CODE_WAIT_RELEASE = 3'd5;
  localparam logic [2:0] CODE_DEBOUNCE     = 3'd6;

  localparam logic [1:0] OP_SAMPLE      = 2'd0;
  localparam logic [1:0] OP_TAKE_SINGLE = 2'd1;
  localparam logic [1:0] OP_TAKE_DOUBLE = 2'd2;
  localparam logic [1:0] OP_TAKE_HOLD   = 2'd3;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_HOLD   = 2'd2;

  localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [2:0] REG_DOUBLE_CLICK = 3'd1;
  localparam logic [2:0] REG_HOLD         = 3'd2;
  localparam logic [2:0] REG_REWAKE       = 3'd3;
  localparam logic [2:0] REG_WAKE_MASK    = 3'd4;

  localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;
  localparam logic [15:0] HOLD_RST         = 16'd1000;
  localparam logic [15:0] REWAKE_RST       = 16'd1000;
  localparam logic [2:0]  WAKE_MASK_RST    = 3'd0;

  typedef struct packed {
    logic        wake;
    logic [15:0] taken_count;
    logic [2:0]  fsm_state;
  } result_t;

  function automatic logic [2:0] state_code(btn_state_e s);
    logic [2:0] c;
    c = CODE_IDLE;
    unique case (s)
      ST_IDLE:         c = CODE_IDLE;
      ST_PRESSED:      c = CODE_PRESSED;
      ST_DOWN:         c = CODE_DOWN;
      ST_RELEASED:     c = CODE_RELEASED;
      ST_UP:           c = CODE_UP;
      ST_WAIT_RELEASE: c = CODE_WAIT_RELEASE;
      ST_DEBOUNCE:     c = CODE_DEBOUNCE;
      default:         c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/button_click_hold_detector.sv @@
// Button click, double click and hold detector for one active-low pin.
// Input channel (in_valid_i / in_stall_o) carries requests: an opcode, the pin
// level and a 32-bit timestamp. A sample request advances the debounce machine;
// a take request returns and acknowledges the events of one kind.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// request: wake flag, taken count and the machine state after the step.
// Configuration writes go through cfg_valid_i / cfg_ready_o with a register
// index and 16-bit data; ready is always high, unknown indexes are dropped.
// The result of a request is registered in the output register, or in the skid
// register while the receiver stalls. Throughput is one request per cycle while
// the skid register is empty, set by the single state update done per request.
// When the receiver stalls, one more result is held in a skid register; the
// input stalls only while that skid register is full.
// Reset clears the machine to idle, all counters and times to zero and the
// timing registers to their defaults; no results are pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module button_click_hold_detector
  import bchd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic        pin_level_i,
  input  wire logic [31:0] now_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             wake_o,
  output logic [15:0]      taken_count_o,
  output logic [2:0]       fsm_state_o
);

  logic [15:0] debounce_q, double_click_q, hold_q, rewake_q;
  logic [2:0]  wake_mask_q;

  btn_state_e  state_q, state_d;
  logic [31:0] mark_q, mark_d;
  logic [31:0] last_wake_q, last_wake_d;
  logic [15:0] ev_q [3];
  logic [15:0] tk_q [3];

  logic        skid_valid_q, out_valid_q;
  result_t     skid_q, out_q, res;

  logic        in_acc, is_sample, pressed;
  logic [1:0]  kind;
  logic [15:0] mark_limit;
  logic        mark_waited, rewake_waited, any_pending, new_event;
  logic        cnt_single, cnt_double, cnt_hold;
  logic [31:0] mark_elapsed, wake_elapsed;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign is_sample   = (opcode_i == OP_SAMPLE);
  assign pressed     = !pin_level_i;
  assign kind        = opcode_i - 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DEBOUNCE_RST;
      double_click_q <= DOUBLE_CLICK_RST;
      hold_q         <= HOLD_RST;
      rewake_q       <= REWAKE_RST;
      wake_mask_q    <= WAKE_MASK_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE:     debounce_q     <= cfg_data_i;
        REG_DOUBLE_CLICK: double_click_q <= cfg_data_i;
        REG_HOLD:         hold_q         <= cfg_data_i;
        REG_REWAKE:       rewake_q       <= cfg_data_i;
        REG_WAKE_MASK:    wake_mask_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // one shared elapsed-time compare against the threshold of the current state
  always_comb begin
    unique case (state_q)
      ST_DOWN: mark_limit = hold_q;
      ST_UP:   mark_limit = double_click_q;
      default: mark_limit = debounce_q;
    endcase
  end

  assign mark_elapsed  = now_time_i - mark_q;
  assign wake_elapsed  = now_time_i - last_wake_q;
  assign mark_waited   = mark_elapsed >= {16'd0, mark_limit};
  assign rewake_waited = wake_elapsed >= {16'd0, rewake_q};

  always_comb begin
    state_d    = state_q;
    mark_d     = mark_q;
    cnt_single = 1'b0;
    cnt_double = 1'b0;
    cnt_hold   = 1'b0;
    unique case (state_q)
      ST_PRESSED: begin
        if (mark_waited) begin
          mark_d  = now_time_i;
          state_d = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (!pressed) begin
          mark_d  = now_time_i;
          state_d = ST_RELEASED;
        end else if (mark_waited) begin
          cnt_hold = 1'b1;
          state_d  = ST_WAIT_RELEASE;
        end
      end
      ST_RELEASED: begin
        if (mark_waited) begin
          mark_d  = now_time_i;
          state_d = ST_UP;
        end
      end
      ST_UP: begin
        if (pressed) begin
          cnt_double = 1'b1;
          state_d    = ST_WAIT_RELEASE;
        end else if (mark_waited) begin
          cnt_single = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_WAIT_RELEASE: begin
        if (!pressed) begin
          mark_d  = now_time_i;
          state_d = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        if (mark_waited) state_d = ST_IDLE;
      end
      default: begin
        if (pressed) begin
          mark_d  = now_time_i;
          state_d = ST_PRESSED;
        end else begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  assign new_event = cnt_single || cnt_double || cnt_hold;

  // pending is judged on the counts after this step's increment
  always_comb begin
    logic [15:0] ev_s, ev_d, ev_h;
    ev_s = ev_q[KIND_SINGLE] + {15'd0, cnt_single};
    ev_d = ev_q[KIND_DOUBLE] + {15'd0, cnt_double};
    ev_h = ev_q[KIND_HOLD] + {15'd0, cnt_hold};
    any_pending = (wake_mask_q[0] && (ev_s != tk_q[KIND_SINGLE])) ||
                  (wake_mask_q[1] && (ev_d != tk_q[KIND_DOUBLE])) ||
                  (wake_mask_q[2] && (ev_h != tk_q[KIND_HOLD]));
  end

  always_comb begin
    last_wake_d     = last_wake_q;
    res.wake        = 1'b0;
    res.taken_count = 16'd0;
    res.fsm_state   = state_code(state_q);
    if (is_sample) begin
      res.fsm_state = state_code(state_d);
      if ((new_event || rewake_waited) && any_pending) begin
        res.wake    = 1'b1;
        last_wake_d = now_time_i;
      end
    end else begin
      res.taken_count = ev_q[kind] - tk_q[kind];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mark_q      <= 32'd0;
      last_wake_q <= 32'd0;
      for (int k = 0; k < 3; k++) begin
        ev_q[k] <= 16'd0;
        tk_q[k] <= 16'd0;
      end
    end else if (in_acc) begin
      if (is_sample) begin
        state_q     <= state_d;
        mark_q      <= mark_d;
        last_wake_q <= last_wake_d;
        if (cnt_single) ev_q[KIND_SINGLE] <= ev_q[KIND_SINGLE] + 16'd1;
        if (cnt_double) ev_q[KIND_DOUBLE] <= ev_q[KIND_DOUBLE] + 16'd1;
        if (cnt_hold)   ev_q[KIND_HOLD]   <= ev_q[KIND_HOLD] + 16'd1;
      end else begin
        tk_q[kind] <= ev_q[kind];
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_acc)  out_q <= res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wake_o        = out_q.wake;
  assign taken_count_o = out_q.taken_count;
  assign fsm_state_o   = out_q.fsm_state;

endmodule

`default_nettype wire
